// ----- rtl/core/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int MAX_CELLS_DEF = 128;
   localparam int ID_BITS_DEF   = 16;

   localparam int MODE_W      = 2;
   localparam int SIZE_W      = 8;
   localparam int EID_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int BID_W       = 16;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CNT_REG_W   = 8;

   localparam logic [CNT_REG_W-1:0] CELL_COUNT_RST = 8'd100;

   // register index taken from paddr[2]
   localparam logic REG_CELL_COUNT = 1'b0;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ERASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PACK  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOROOM  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FILL,
      S_ERASE,
      S_PACK,
      S_ZERO,
      S_RESP_OK,
      S_RESP_ALLOC,
      S_RESP_NOROOM,
      S_RESP_ILLEGAL,
      S_RESP_ERASE
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CLEAR,
      PH_SCAN,
      PH_FILL,
      PH_ERASE,
      PH_PACK,
      PH_ZERO
   } phase_type;

   typedef enum logic [2:0] {
      RES_OK,
      RES_ALLOC,
      RES_NOROOM,
      RES_ILLEGAL,
      RES_ERASE
   } res_type;

   typedef struct packed {
      logic      start;
      phase_type phase;
      logic      load_rsp;
      res_type   res_kind;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_found;
      logic scan_end;
      logic fill_last;
      logic zero_end;
      logic alloc_bad;
      logic erase_bad;
      logic rsp_free;
   } sts_type;

endpackage

// ----- rtl/core/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ffba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: steps the datapath through clear, scan, fill, erase, pack, zero
// and result phases.
// ----------------------------------------------------------------------------
module ffba_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic [ffba_pkg::MODE_W-1:0] req_mode,
   output logic                       req_tready,
   input  ffba_pkg::sts_type          sts,
   output ffba_pkg::cmd_type          cmd
);
   import ffba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_mode)
                  MODE_ALLOC: state_in = sts.alloc_bad ? S_RESP_NOROOM : S_SCAN;
                  MODE_ERASE: state_in = sts.erase_bad ? S_RESP_ILLEGAL : S_ERASE;
                  MODE_PACK:  state_in = S_PACK;
                  default:    state_in = S_RESP_OK;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.scan_found) begin
               state_in = S_FILL;
            end else if (sts.scan_end) begin
               state_in = S_RESP_NOROOM;
            end
         end
         S_FILL: begin
            if (sts.fill_last) state_in = S_RESP_ALLOC;
         end
         S_ERASE: begin
            if (sts.scan_end) state_in = S_RESP_ERASE;
         end
         S_PACK: begin
            if (sts.scan_end) state_in = S_ZERO;
         end
         S_ZERO: begin
            if (sts.zero_end) state_in = S_RESP_OK;
         end
         S_RESP_OK, S_RESP_ALLOC, S_RESP_NOROOM, S_RESP_ILLEGAL, S_RESP_ERASE: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd.start    = 1'b0;
      cmd.phase    = PH_IDLE;
      cmd.load_rsp = 1'b0;
      cmd.res_kind = RES_OK;
      unique case (state_ff)
         S_CLEAR: cmd.phase = PH_CLEAR;
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         S_SCAN:  cmd.phase = PH_SCAN;
         S_FILL:  cmd.phase = PH_FILL;
         S_ERASE: cmd.phase = PH_ERASE;
         S_PACK:  cmd.phase = PH_PACK;
         S_ZERO:  cmd.phase = PH_ZERO;
         S_RESP_OK: begin
            cmd.load_rsp = 1'b1;
            cmd.res_kind = RES_OK;
         end
         S_RESP_ALLOC: begin
            cmd.load_rsp = 1'b1;
            cmd.res_kind = RES_ALLOC;
         end
         S_RESP_NOROOM: begin
            cmd.load_rsp = 1'b1;
            cmd.res_kind = RES_NOROOM;
         end
         S_RESP_ILLEGAL: begin
            cmd.load_rsp = 1'b1;
            cmd.res_kind = RES_ILLEGAL;
         end
         S_RESP_ERASE: begin
            cmd.load_rsp = 1'b1;
            cmd.res_kind = RES_ERASE;
         end
         default: cmd.phase = PH_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/ffba_dp.sv -----
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: cell store, scan pointers, id counter, config register and the
// result register.
// ----------------------------------------------------------------------------
module ffba_dp #(
   parameter int MAX_CELLS = ffba_pkg::MAX_CELLS_DEF,
   parameter int ID_BITS   = ffba_pkg::ID_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ffba_pkg::cmd_type               cmd,
   output ffba_pkg::sts_type               sts,
   input  logic [ffba_pkg::SIZE_W-1:0]     alloc_size,
   input  logic [ffba_pkg::EID_W-1:0]      erase_id,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ffba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffba_pkg::BID_W-1:0]      rsp_block_id,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ffba_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ffba_pkg::CSR_DATA_W-1:0] csr_prdata
);
   import ffba_pkg::*;

   localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CW   = $clog2(MAX_CELLS + 1);
   localparam int CMPW = (CW > CNT_REG_W) ? CW : CNT_REG_W;
   localparam int EW   = (ID_BITS > EID_W) ? ID_BITS : EID_W;
   localparam logic [CMPW-1:0] MAXC = CMPW'(MAX_CELLS);
   localparam logic [CW-1:0]   LAST_CELL = CW'(MAX_CELLS - 1);

   logic [CNT_REG_W-1:0] cfg_count_ff, cfg_count_in;
   logic [ID_BITS-1:0]   last_id_ff, last_id_in;
   logic [SIZE_W-1:0]    want_ff, want_in;
   logic [ID_BITS-1:0]   eid_ff, eid_in;
   logic [CW-1:0]        rd_ff, rd_in;
   logic [CW-1:0]        ev_ff, ev_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [CW-1:0]        wr_ff, wr_in;
   logic [CW-1:0]        end_ff, end_in;
   logic [SIZE_W-1:0]    run_ff, run_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [BID_W-1:0]     rsp_id_ff, rsp_id_in;

   logic [CMPW-1:0]    cfg_ext;
   logic [CW-1:0]      used_n;
   logic [EW-1:0]      eid_w;
   logic [EW-1:0]      id_w;
   logic [ID_BITS-1:0] cell_rd;
   logic               cell_free;
   logic [SIZE_W:0]    run_inc;
   logic               rd_more;
   logic               scan_hit;
   logic               csr_wr;
   logic               rsp_free;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ID_BITS-1:0] mem_wdata;

   ffba_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (MAX_CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_ff[AW-1:0]),
      .rd_data (cell_rd)
   );

   assign cfg_ext   = CMPW'(cfg_count_ff);
   assign used_n    = (cfg_ext > MAXC) ? CW'(MAXC) : CW'(cfg_ext);
   assign eid_w     = EW'(erase_id);
   assign id_w      = EW'(last_id_ff);
   assign cell_free = (cell_rd == '0);
   assign run_inc   = {1'b0, run_ff} + {{SIZE_W{1'b0}}, 1'b1};
   assign rd_more   = (rd_ff < used_n);
   assign scan_hit  = ev_valid_ff && cell_free && (run_inc >= {1'b0, want_ff});
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[2] == REG_CELL_COUNT);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   assign csr_prdata = (csr_paddr[2] == REG_CELL_COUNT)
                       ? CSR_DATA_W'(cfg_count_ff) : '0;

   always_comb begin
      sts.clear_last = (wr_ff == LAST_CELL);
      sts.scan_found = scan_hit;
      sts.scan_end   = !ev_valid_ff && !rd_more;
      sts.fill_last  = (CW'(wr_ff + 1'b1) == end_ff);
      sts.zero_end   = !(wr_ff < used_n);
      sts.alloc_bad  = (alloc_size == '0) || (&last_id_ff);
      sts.erase_bad  = (eid_w == '0) || ((eid_w >> ID_BITS) != '0);
      sts.rsp_free   = rsp_free;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_ff[AW-1:0];
      mem_wdata = '0;
      case (cmd.phase)
         PH_CLEAR: mem_we = 1'b1;
         PH_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = last_id_ff;
         end
         PH_ERASE: begin
            mem_we    = ev_valid_ff && (cell_rd == eid_ff);
            mem_waddr = ev_ff[AW-1:0];
         end
         PH_PACK: begin
            mem_we    = ev_valid_ff && !cell_free;
            mem_wdata = cell_rd;
         end
         PH_ZERO: mem_we = (wr_ff < used_n);
         default: mem_we = 1'b0;
      endcase
   end

   always_comb begin
      cfg_count_in  = cfg_count_ff;
      last_id_in    = last_id_ff;
      want_in       = want_ff;
      eid_in        = eid_ff;
      rd_in         = rd_ff;
      ev_in         = ev_ff;
      ev_valid_in   = ev_valid_ff;
      wr_in         = wr_ff;
      end_in        = end_ff;
      run_in        = run_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;

      if (csr_wr) cfg_count_in = csr_pwdata[CNT_REG_W-1:0];

      if (cmd.start) begin
         want_in     = alloc_size;
         eid_in      = eid_w[ID_BITS-1:0];
         rd_in       = '0;
         ev_valid_in = 1'b0;
         wr_in       = '0;
         run_in      = '0;
         hit_in      = 1'b0;
      end

      if (cmd.phase == PH_SCAN || cmd.phase == PH_ERASE || cmd.phase == PH_PACK) begin
         rd_in       = rd_more ? CW'(rd_ff + 1'b1) : rd_ff;
         ev_in       = rd_ff;
         ev_valid_in = rd_more;
      end

      case (cmd.phase)
         PH_CLEAR, PH_FILL: wr_in = CW'(wr_ff + 1'b1);
         PH_SCAN: begin
            if (ev_valid_ff) run_in = cell_free ? run_inc[SIZE_W-1:0] : '0;
            if (scan_hit) begin
               end_in     = CW'(ev_ff + 1'b1);
               wr_in      = CW'(ev_ff + 1'b1 - CW'(want_ff));
               last_id_in = last_id_ff + 1'b1;
            end
         end
         PH_ERASE: begin
            if (ev_valid_ff && (cell_rd == eid_ff)) hit_in = 1'b1;
         end
         PH_PACK: begin
            if (ev_valid_ff && !cell_free) wr_in = CW'(wr_ff + 1'b1);
         end
         PH_ZERO: begin
            if (wr_ff < used_n) wr_in = CW'(wr_ff + 1'b1);
         end
         default: ;
      endcase

      if (cmd.load_rsp && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = '0;
         case (cmd.res_kind)
            RES_ALLOC: begin
               rsp_status_in = STATUS_OK;
               rsp_id_in     = id_w[BID_W-1:0];
            end
            RES_NOROOM:  rsp_status_in = STATUS_NOROOM;
            RES_ILLEGAL: rsp_status_in = STATUS_ILLEGAL;
            RES_ERASE:   rsp_status_in = hit_ff ? STATUS_OK : STATUS_ILLEGAL;
            default:     rsp_status_in = STATUS_OK;
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff <= CELL_COUNT_RST;
         last_id_ff   <= '0;
         rd_ff        <= '0;
         ev_valid_ff  <= 1'b0;
         wr_ff        <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_count_ff <= cfg_count_in;
         last_id_ff   <= last_id_in;
         rd_ff        <= rd_in;
         ev_valid_ff  <= ev_valid_in;
         wr_ff        <= wr_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      want_ff       <= want_in;
      eid_ff        <= eid_in;
      ev_ff         <= ev_in;
      end_ff        <= end_in;
      run_ff        <= run_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_block_id = rsp_id_ff;

endmodule

// ----- rtl/core/first_fit_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit contiguous cell allocator with erase and compaction.
// ----------------------------------------------------------------------------
// Requests are handled one at a time against a one-write, one-read cell RAM
// that is walked one cell per clock, so the time per request follows the
// cell count n (cell_count, capped at MAX_CELLS): alloc scans up to the
// first fitting run, or all n cells when nothing fits, and then fills the
// run, erase walks all n cells, defragment copies the owned cells of all n
// cells down and then zeroes the rest, and every request then loads its
// result beat; a zero size alloc, an alloc with the ids used up, an erase of
// id zero and the unused mode skip the cell walk and go straight to their
// result beat. A new request is taken while the previous result beat still
// waits. After reset a clearing pass over all MAX_CELLS cells zeroes the
// cell RAM and holds req_tready low; configuration writes are taken at any
// time but should only be issued while the block is idle.
module first_fit_block_allocator_core #(
   parameter int MAX_CELLS = ffba_pkg::MAX_CELLS_DEF,
   parameter int ID_BITS   = ffba_pkg::ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] mode, [9:2] alloc_size, [25:10] erase_id, [31:26] zero
   input  logic [ffba_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [17:2] block_id, [23:18] zero
   output logic [ffba_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ffba_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ffba_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import ffba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   logic [MODE_W-1:0]   req_mode;
   logic [SIZE_W-1:0]   req_size;
   logic [EID_W-1:0]    req_eid;
   logic [STATUS_W-1:0] rsp_status;
   logic [BID_W-1:0]    rsp_block_id;

   assign req_mode = req_tdata[MODE_W-1:0];
   assign req_size = req_tdata[MODE_W+SIZE_W-1:MODE_W];
   assign req_eid  = req_tdata[MODE_W+SIZE_W+EID_W-1:MODE_W+SIZE_W];

   assign rsp_tdata  = {{(RSP_TDATA_W-STATUS_W-BID_W){1'b0}}, rsp_block_id, rsp_status};
   assign csr_pready = 1'b1;

   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_mode),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffba_dp #(
      .MAX_CELLS (MAX_CELLS),
      .ID_BITS   (ID_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .alloc_size   (req_size),
      .erase_id     (req_eid),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_block_id (rsp_block_id),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata)
   );

endmodule

// ----- rtl/core/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ffba_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ffba_pkg::*;

   // result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == STATUS_OK || rsp_tdata[1:0] == STATUS_NOROOM
                      || rsp_tdata[1:0] == STATUS_ILLEGAL))
      else $error("bad status code");

   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STATUS_OK |-> rsp_tdata[17:2] == '0)
      else $error("failed result carries an id");

   // clearing pass after reset blocks requests
   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ready during clearing pass");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/ffba_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_tb_checker
// Watches the request, result and register ports of the allocator, keeps its
// own copy of the cell owners, id counter and cell count, predicts every
// result beat and compares it field by field, in order.
// ----------------------------------------------------------------------------
module ffba_tb_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ffba_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ffba_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ffba_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [ffba_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  logic                             csr_pready,
   output int                               fail_count
);
   import ffba_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BID_W-1:0]    block_id;
   } reply_type;

   logic [BID_W-1:0]     owner_of [MAX_CELLS_DEF];
   logic [BID_W-1:0]     last_granted;
   logic [CNT_REG_W-1:0] cells_cfg;
   reply_type            replies_due [$];
   int                   mismatches = 0;
   int                   pending = 0;

   assign fail_count = mismatches + pending;

   function automatic reply_type apply_request(input logic [MODE_W-1:0] mode,
                                               input logic [SIZE_W-1:0] size,
                                               input logic [EID_W-1:0]  eid);
      reply_type r;
      int        n;
      int        run;
      int        at;
      int        wr;
      bit        hit;
      r.status   = STATUS_OK;
      r.block_id = '0;
      n = (cells_cfg > MAX_CELLS_DEF) ? MAX_CELLS_DEF : int'(cells_cfg);
      case (mode)
         MODE_ALLOC: begin
            r.status = STATUS_NOROOM;
            if (size != 0 && last_granted != '1) begin
               run = 0;
               at  = -1;
               for (int i = 0; i < n && at < 0; i++) begin
                  run = (owner_of[i] == '0) ? run + 1 : 0;
                  if (run >= int'(size))
                     at = i + 1 - int'(size);
               end
               if (at >= 0) begin
                  last_granted = last_granted + 1'b1;
                  for (int i = at; i < at + int'(size); i++)
                     owner_of[i] = last_granted;
                  r.status   = STATUS_OK;
                  r.block_id = last_granted;
               end
            end
         end
         MODE_ERASE: begin
            hit = 1'b0;
            if (eid != '0) begin
               for (int i = 0; i < n; i++) begin
                  if (owner_of[i] == eid) begin
                     owner_of[i] = '0;
                     hit = 1'b1;
                  end
               end
            end
            r.status = hit ? STATUS_OK : STATUS_ILLEGAL;
         end
         MODE_PACK: begin
            wr = 0;
            for (int rd = 0; rd < n; rd++) begin
               if (owner_of[rd] != '0) begin
                  owner_of[wr] = owner_of[rd];
                  wr++;
               end
            end
            while (wr < n) begin
               owner_of[wr] = '0;
               wr++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type got;
      reply_type want;
      if (reset) begin
         for (int i = 0; i < MAX_CELLS_DEF; i++)
            owner_of[i] = '0;
         last_granted = '0;
         cells_cfg    = CELL_COUNT_RST;
         replies_due.delete();
         pending = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == REG_CELL_COUNT) begin
            if (csr_pwrite) begin
               cells_cfg = csr_pwdata[CNT_REG_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(cells_cfg)) begin
               $display("%0t: cell_count read expected %0d got %0d",
                        $time, cells_cfg, csr_prdata);
               mismatches++;
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(apply_request(req_tdata[MODE_W-1:0],
                                                req_tdata[MODE_W +: SIZE_W],
                                                req_tdata[MODE_W+SIZE_W +: EID_W]));
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tdata[STATUS_W-1:0];
            got.block_id = rsp_tdata[STATUS_W +: BID_W];
            if (replies_due.size() == 0) begin
               $display("%0t: result beat expected none got status %0d block_id %0d",
                        $time, got.status, got.block_id);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, got.status);
                  mismatches++;
               end
               if (got.block_id !== want.block_id) begin
                  $display("%0t: block_id expected %0d got %0d",
                           $time, want.block_id, got.block_id);
                  mismatches++;
               end
            end
         end
         pending = replies_due.size();
      end
   end

endmodule

// ----- sim/first_fit_block_allocator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core_tb
// Drives alloc, erase, defragment and spare-mode requests into the allocator
// with random request gaps and random result back-pressure, across a range
// of cell counts set over the register port. Checking is by ffba_tb_checker.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core_tb;
   import ffba_pkg::*;

   localparam logic [MODE_W-1:0]     MODE_SPARE      = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CELL_COUNT = {REG_CELL_COUNT, 2'b00};
   localparam int                    STALL_LIMIT     = 4000;
   localparam int                    PHASE_ITEMS     = 76;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;
   int                     fail_count;

   bit steady      = 1'b0;
   int req_count   = 0;
   int rsp_count   = 0;
   int granted_max = 0;
   int phase_cells [16] = '{16, 8, 32, 1, 100, 24, 128, 12, 200, 40, 4, 64, 20, 2, 48, 10};

   first_fit_block_allocator_core dut (.*);
   ffba_tb_checker check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 28);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count <= rsp_count + 1;
         if (rsp_tdata[STATUS_W-1:0] == STATUS_OK && rsp_tdata[STATUS_W +: BID_W] > granted_max)
            granted_max <= int'(rsp_tdata[STATUS_W +: BID_W]);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic send_req(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
                           input logic [EID_W-1:0] eid);
      logic [SIZE_W-1:0] size_f;
      logic [EID_W-1:0]  eid_f;
      size_f = (mode == MODE_ALLOC) ? size : SIZE_W'($urandom);
      eid_f  = (mode == MODE_ERASE) ? eid : EID_W'($urandom);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-MODE_W-SIZE_W-EID_W){1'b0}}, eid_f, size_f, mode};
      do begin
         @(posedge clock);
      end while (!req_tready);
      req_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (rsp_count != req_count)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_rw(input bit wr, input logic [CNT_REG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_CELL_COUNT;
      csr_pwdata  <= wr ? CSR_DATA_W'(value) : '0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_cell_count(input logic [CNT_REG_W-1:0] value);
      drain();
      csr_rw(1'b1, value);
      @(negedge clock);
      csr_rw(1'b0, '0);
   endtask

   task automatic random_item(input int n);
      int                pick;
      int                span;
      logic [SIZE_W-1:0] size;
      logic [EID_W-1:0]  eid;
      pick = $urandom_range(99);
      if (pick < 46) begin
         span = $urandom_range(9);
         if (span < 7)
            size = SIZE_W'($urandom_range(n > 4 ? n / 4 : 1, 1));
         else if (span < 9)
            size = SIZE_W'($urandom_range(n, 1));
         else
            size = SIZE_W'($urandom_range(255));
         send_req(MODE_ALLOC, size, '0);
      end else if (pick < 82) begin
         if ($urandom_range(9) < 8)
            eid = EID_W'(granted_max
                         - int'($urandom_range(granted_max < 30 ? granted_max : 30, 0)));
         else
            eid = EID_W'($urandom);
         send_req(MODE_ERASE, '0, eid);
      end else if (pick < 92) begin
         send_req(MODE_PACK, '0, '0);
      end else if (pick < 96) begin
         send_req(MODE_SPARE, '0, '0);
      end else begin
         send_req(MODE_ALLOC, '0, '0);
      end
   endtask

   initial begin : stimulus
      int n;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);

      // default count of 100 cells
      send_req(MODE_ALLOC, 8'd0, '0);
      send_req(MODE_ERASE, '0, 16'd0);
      send_req(MODE_ERASE, '0, 16'hFFFF);
      send_req(MODE_ALLOC, 8'd10, '0);
      send_req(MODE_ALLOC, 8'd1, '0);
      send_req(MODE_ALLOC, 8'd20, '0);
      send_req(MODE_ALLOC, 8'd255, '0);
      send_req(MODE_ALLOC, 8'd128, '0);
      send_req(MODE_ERASE, '0, 16'd2);
      send_req(MODE_ALLOC, 8'd1, '0);
      send_req(MODE_ERASE, '0, 16'd1);
      send_req(MODE_ALLOC, 8'd5, '0);
      send_req(MODE_PACK, '0, '0);
      send_req(MODE_SPARE, '0, '0);
      send_req(MODE_ALLOC, 8'd74, '0);
      send_req(MODE_ALLOC, 8'd1, '0);

      // no cells at all
      set_cell_count(8'd0);
      send_req(MODE_ALLOC, 8'd1, '0);
      send_req(MODE_ERASE, '0, 16'd3);
      send_req(MODE_PACK, '0, '0);

      // count above the built size saturates
      set_cell_count(8'd255);
      send_req(MODE_ALLOC, 8'd28, '0);
      send_req(MODE_ALLOC, 8'd1, '0);
      send_req(MODE_ERASE, '0, 16'd6);
      send_req(MODE_PACK, '0, '0);
      send_req(MODE_ALLOC, 8'd74, '0);

      for (int p = 0; p < 16; p++) begin
         set_cell_count(CNT_REG_W'(phase_cells[p]));
         steady <= (p == 5 || p == 6);
         n = (phase_cells[p] > MAX_CELLS_DEF) ? MAX_CELLS_DEF : phase_cells[p];
         repeat (PHASE_ITEMS) random_item(n);
      end

      // single cell, then the full built size
      set_cell_count(8'd1);
      steady <= 1'b0;
      send_req(MODE_ALLOC, 8'd1, '0);
      send_req(MODE_ALLOC, 8'd0, '0);
      send_req(MODE_ERASE, '0, 16'hFFFF);
      set_cell_count(8'd128);
      send_req(MODE_ALLOC, 8'd3, '0);
      send_req(MODE_PACK, '0, '0);

      drain();
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_dp.sv
rtl/core/first_fit_block_allocator_core.sv
rtl/core/ffba_checker.sv
sim/ffba_checker.sv
sim/first_fit_block_allocator_core_tb.sv
